// File: rtl/sbzd_pkg.sv
// Shared types, constants and helpers for the scan-line bitmap zero decompressor.
// Depends on nothing; every other file but sbzd_line_store refers to it by scoped names.
package sbzd_pkg;

  // Field widths fixed by the interface.
  localparam int WIDX_W = 6;
  localparam int NB_W   = 4;
  localparam int LB_W   = 10;
  localparam int POS_W  = 4;
  localparam int FILL_W = 7;

  // Line length after reset.
  localparam logic [LB_W-1:0] LB_RESET = 10'd512;

  // A flag position of eight means the level is used up.
  localparam logic [POS_W-1:0] POS_END = 4'd8;

  // Zero-fill sizes of one flag bit at each level, in bytes.
  localparam logic [FILL_W-1:0] LEAF_GROUP = 7'd1;
  localparam logic [FILL_W-1:0] MID_GROUP  = 7'd8;
  localparam logic [FILL_W-1:0] TOP_GROUP  = 7'd64;

  // Sequencer states: waiting for a flag or data byte, or running.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_LEAF,
    ST_DATA,
    ST_RUN
  } seq_state_t;

  // Level that a zero fill belongs to.
  typedef enum logic [1:0] {
    LVL_LEAF,
    LVL_MID,
    LVL_TOP
  } fill_level_t;

  // One line word, as handed from the sequencer and as delivered.
  typedef struct packed {
    logic [63:0]       data;
    logic [WIDX_W-1:0] idx;
    logic [NB_W-1:0]   nbytes;
    logic              line_end;
    logic              run_last;
  } word_t;

  // Byte mask that keeps the first nb bytes of a word, first byte on top.
  function automatic logic [63:0] byte_mask(input logic [NB_W-1:0] nb);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (NB_W'(k) < nb) begin
        m[63 - 8 * k -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/sbzd_line_store.sv
// Previous-line store: one word per entry, synchronous read with the data in the cycle after the read.
// A per-entry valid bit makes unwritten entries read as zero after reset.
// Depends on nothing outside this file.
module sbzd_line_store #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [63:0]                           wdata,
  output logic [63:0]                           rdata
);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [63:0]      mem_q;
  logic             written_q;
  logic             bypass;
  logic [63:0]      bypass_data;

  // Array write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  // Entry valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      written_q   <= written[raddr];
      bypass      <= we && (waddr == raddr);
      bypass_data <= wdata;
    end
  end

  assign rdata = bypass ? bypass_data : (written_q ? mem_q : 64'd0);

endmodule

// File: rtl/sbzd_word_unit.sv
// Read-modify-write of line words: XOR the delta into the stored line, write back,
// and register the inverted result. Depends on sbzd_pkg and sbzd_line_store.
module sbzd_word_unit #(
  parameter int WORDS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sbzd_pkg::word_t req,
  output logic           out_valid,
  input  logic           out_ready,
  output sbzd_pkg::word_t res
);

  localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic            w_valid;
  sbzd_pkg::word_t w_req;
  logic            load_w;
  logic            move_o;
  logic [63:0]     prev;
  logic [63:0]     mask;
  logic [63:0]     merged;

  // Stage handshakes: the read stage moves on when the output register frees.
  assign move_o    = w_valid && (!out_valid || out_ready);
  assign req_ready = !w_valid || move_o;
  assign load_w    = req_valid && req_ready;

  // New line word for the entry under update.
  assign mask   = sbzd_pkg::byte_mask(w_req.nbytes);
  assign merged = prev ^ (w_req.data & mask);

  sbzd_line_store #(
    .DEPTH (WORDS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .re    (load_w),
    .raddr (req.idx[IDX_W-1:0]),
    .we    (move_o),
    .waddr (w_req.idx[IDX_W-1:0]),
    .wdata (merged),
    .rdata (prev)
  );

  // Read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (load_w) begin
      w_valid <= 1'b1;
    end else if (move_o) begin
      w_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      w_req <= req;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_o) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_o) begin
      res.data     <= ~merged & mask;
      res.idx      <= w_req.idx;
      res.nbytes   <= w_req.nbytes;
      res.line_end <= w_req.line_end;
      res.run_last <= w_req.run_last;
    end
  end

endmodule

// File: rtl/sbzd_sequencer.sv
// Flag-tree sequencer: walks the top, middle and leaf flag bytes, places data
// bytes, fills zero runs and builds line words. Depends on sbzd_pkg.
module sbzd_sequencer #(
  parameter int MAX_LINE_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sbzd_pkg::LB_W-1:0]     line_bytes,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    code_byte,
  input  logic                          line_start,
  output logic                          req_valid,
  input  logic                          req_ready,
  output sbzd_pkg::word_t               req
);

  localparam int BD_W = $clog2(MAX_LINE_BYTES + 1);
  localparam logic [sbzd_pkg::LB_W-1:0] MAX_LEN = sbzd_pkg::LB_W'(MAX_LINE_BYTES);

  sbzd_pkg::seq_state_t  state, state_next;
  logic [7:0]            top_flags, top_flags_next;
  logic [7:0]            mid_flags, mid_flags_next;
  logic [7:0]            leaf_flags, leaf_flags_next;
  logic [sbzd_pkg::POS_W-1:0]  top_pos, top_pos_next;
  logic [sbzd_pkg::POS_W-1:0]  mid_pos, mid_pos_next;
  logic [sbzd_pkg::POS_W-1:0]  leaf_pos, leaf_pos_next;
  logic [sbzd_pkg::FILL_W-1:0] fill_left, fill_left_next;
  sbzd_pkg::fill_level_t fill_level, fill_level_next;
  logic [63:0]           wuc, wuc_next;
  logic [BD_W-1:0]       bd, bd_next;
  logic                  pend_valid, pend_valid_next;
  sbzd_pkg::word_t       pend, pend_next;

  logic [sbzd_pkg::LB_W-1:0]   len10;
  logic [BD_W-1:0]             len;
  logic                        accept;
  logic                        chunk;
  logic                        merge;
  logic                        term;
  sbzd_pkg::seq_state_t        term_state;
  logic [sbzd_pkg::FILL_W-1:0] avail;
  sbzd_pkg::fill_level_t       level;

  logic [2:0]                  pos;
  logic [3:0]                  room;
  logic [sbzd_pkg::LB_W-1:0]   rem10;
  logic [sbzd_pkg::FILL_W-1:0] n_a;
  logic [3:0]                  n;
  logic [BD_W-1:0]             bd_new;
  logic [BD_W-1:0]             bd_m1;
  logic [3:0]                  vb;
  logic                        line_done;
  logic                        word_done;
  logic                        group_done;
  logic [sbzd_pkg::FILL_W-1:0] left;
  logic [63:0]                 wuc_m;
  sbzd_pkg::word_t             new_word;

  logic                        want_push;
  logic                        stall;
  logic [sbzd_pkg::POS_W-1:0]  top_inc, mid_inc, leaf_inc;

  // Line length in use, clamped to one .. maximum.
  always_comb begin
    priority if (line_bytes == '0) begin
      len10 = sbzd_pkg::LB_W'(1);
    end else if (line_bytes > MAX_LEN) begin
      len10 = MAX_LEN;
    end else begin
      len10 = line_bytes;
    end
  end
  assign len = len10[BD_W-1:0];

  assign in_ready = (state != sbzd_pkg::ST_RUN);
  assign accept   = in_valid && in_ready;

  // Decide what this cycle does: one step of the zero run, the placing of a data byte, or stop and wait.
  always_comb begin
    chunk      = 1'b0;
    merge      = 1'b0;
    term       = 1'b0;
    term_state = sbzd_pkg::ST_IDLE;
    avail      = sbzd_pkg::LEAF_GROUP;
    level      = sbzd_pkg::LVL_LEAF;
    unique case (state)
      sbzd_pkg::ST_RUN: begin
        priority if (fill_left != '0) begin
          chunk = 1'b1;
          avail = fill_left;
          level = fill_level;
        end else if (bd >= len) begin
          term = 1'b1;
        end else if (!leaf_pos[3]) begin
          if (leaf_flags[3'd7 - leaf_pos[2:0]]) begin
            term       = 1'b1;
            term_state = sbzd_pkg::ST_DATA;
          end else begin
            chunk = 1'b1;
          end
        end else if (!mid_pos[3]) begin
          if (mid_flags[3'd7 - mid_pos[2:0]]) begin
            term       = 1'b1;
            term_state = sbzd_pkg::ST_LEAF;
          end else begin
            chunk = 1'b1;
            avail = sbzd_pkg::MID_GROUP;
            level = sbzd_pkg::LVL_MID;
          end
        end else if (!top_pos[3]) begin
          if (top_flags[3'd7 - top_pos[2:0]]) begin
            term       = 1'b1;
            term_state = sbzd_pkg::ST_MID;
          end else begin
            chunk = 1'b1;
            avail = sbzd_pkg::TOP_GROUP;
            level = sbzd_pkg::LVL_TOP;
          end
        end else begin
          term = 1'b1;
        end
      end
      sbzd_pkg::ST_DATA: begin
        if (accept && !line_start) begin
          chunk = 1'b1;
          merge = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Bytes placed this cycle: up to the word boundary, the group end or the line end.
  always_comb begin
    pos   = bd[2:0];
    room  = 4'd8 - {1'b0, pos};
    rem10 = sbzd_pkg::LB_W'(len) - sbzd_pkg::LB_W'(bd);
    n_a   = (avail < {3'b000, room}) ? avail : {3'b000, room};
    if (merge) begin
      n = 4'd1;
    end else if ({3'b000, n_a} > rem10) begin
      n = rem10[3:0];
    end else begin
      n = n_a[3:0];
    end
    bd_new     = bd + BD_W'(n);
    bd_m1      = bd_new - BD_W'(1);
    vb         = {1'b0, pos} + n;
    line_done  = (bd_new >= len);
    word_done  = (vb == 4'd8) || line_done;
    left       = avail - {3'b000, n};
    group_done = (left == '0) || line_done;
    wuc_m      = merge ? (wuc | ({56'd0, code_byte} << (6'd56 - {pos, 3'b000}))) : wuc;

    new_word.data     = wuc_m;
    new_word.idx      = sbzd_pkg::WIDX_W'(bd_m1 >> 3);
    new_word.nbytes   = vb;
    new_word.line_end = line_done;
    new_word.run_last = 1'b0;
  end

  // Position increments; the top position stays at its end once that level is exhausted.
  assign leaf_inc = leaf_pos + 4'd1;
  assign mid_inc  = mid_pos + 4'd1;
  assign top_inc  = top_pos[3] ? top_pos : top_pos + 4'd1;

  // Next state and the word handed downstream. A word waits in the pending
  // register until the next step shows whether it closes this input's results.
  always_comb begin
    state_next      = state;
    top_flags_next  = top_flags;
    mid_flags_next  = mid_flags;
    leaf_flags_next = leaf_flags;
    top_pos_next    = top_pos;
    mid_pos_next    = mid_pos;
    leaf_pos_next   = leaf_pos;
    fill_left_next  = fill_left;
    fill_level_next = fill_level;
    wuc_next        = wuc;
    bd_next         = bd;
    pend_valid_next = pend_valid;
    pend_next       = pend;

    want_push    = pend_valid && (term || (chunk && word_done));
    stall        = want_push && !req_ready;
    req_valid    = want_push;
    req          = pend;
    req.run_last = term;

    if (accept && line_start) begin
      bd_next        = '0;
      wuc_next       = '0;
      top_flags_next = code_byte;
      top_pos_next   = '0;
      mid_pos_next   = sbzd_pkg::POS_END;
      leaf_pos_next  = sbzd_pkg::POS_END;
      fill_left_next = '0;
      state_next     = sbzd_pkg::ST_RUN;
    end else if (accept) begin
      unique case (state)
        sbzd_pkg::ST_MID: begin
          mid_flags_next = code_byte;
          mid_pos_next   = '0;
          leaf_pos_next  = sbzd_pkg::POS_END;
          state_next     = sbzd_pkg::ST_RUN;
        end
        sbzd_pkg::ST_LEAF: begin
          leaf_flags_next = code_byte;
          leaf_pos_next   = '0;
          state_next      = sbzd_pkg::ST_RUN;
        end
        sbzd_pkg::ST_DATA: begin
          state_next = sbzd_pkg::ST_RUN;
        end
        default: begin
        end
      endcase
    end

    if (!stall) begin
      if (chunk) begin
        bd_next  = bd_new;
        wuc_next = word_done ? 64'd0 : wuc_m;
        if (word_done) begin
          pend_next       = new_word;
          pend_valid_next = 1'b1;
        end
        if (group_done) begin
          fill_left_next = '0;
          unique case (level)
            sbzd_pkg::LVL_LEAF: begin
              if (leaf_inc[3]) begin
                leaf_pos_next = sbzd_pkg::POS_END;
                if (mid_inc[3]) begin
                  mid_pos_next = sbzd_pkg::POS_END;
                  top_pos_next = top_inc;
                end else begin
                  mid_pos_next = mid_inc;
                end
              end else begin
                leaf_pos_next = leaf_inc;
              end
            end
            sbzd_pkg::LVL_MID: begin
              if (mid_inc[3]) begin
                mid_pos_next = sbzd_pkg::POS_END;
                top_pos_next = top_inc;
              end else begin
                mid_pos_next = mid_inc;
              end
            end
            sbzd_pkg::LVL_TOP: begin
              top_pos_next = top_inc;
            end
            default: begin
            end
          endcase
        end else begin
          fill_left_next  = left;
          fill_level_next = level;
        end
      end else if (term) begin
        state_next = term_state;
        if (want_push) begin
          pend_valid_next = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbzd_pkg::ST_IDLE;
      top_flags  <= '0;
      mid_flags  <= '0;
      leaf_flags <= '0;
      top_pos    <= '0;
      mid_pos    <= '0;
      leaf_pos   <= '0;
      fill_left  <= '0;
      fill_level <= sbzd_pkg::LVL_LEAF;
      wuc        <= '0;
      bd         <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      top_flags  <= top_flags_next;
      mid_flags  <= mid_flags_next;
      leaf_flags <= leaf_flags_next;
      top_pos    <= top_pos_next;
      mid_pos    <= mid_pos_next;
      leaf_pos   <= leaf_pos_next;
      fill_left  <= fill_left_next;
      fill_level <= fill_level_next;
      wuc        <= wuc_next;
      bd         <= bd_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Pending word payload.
  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

endmodule

// File: rtl/scanline_bitmap_zero_decompressor.sv
// Top level of the scan-line bitmap zero decompressor: line length register,
// flag-tree sequencer and read-modify-write word unit. Depends on sbzd_pkg,
// sbzd_sequencer and sbzd_word_unit.
//
//  Channel   Handshake                 Beat carries
//  input     in_valid / in_ready       code_byte, line_start
//  result    out_valid / out_ready     pixel_word, word_index, valid_bytes, line_end, run_last
//  config    line_bytes_we             line_bytes
//
// An input byte is accepted, then the sequencer runs its steps before it takes the next byte.
// Zero groups of 8 or 64 bytes give one word per cycle while the word unit takes them;
// a zero leaf bit fills a single byte per run step.
// Each word passes a two-stage read-modify-write of the line store (registered read,
// same-entry bypass) and an output register, so in_ready falls only while the
// sequencer runs. Reset clears the line store at once through per-word valid bits.
// A stalled result holds the word unit, which in turn holds the sequencer.
module scanline_bitmap_zero_decompressor #(
  parameter int MAX_LINE_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        line_bytes_we,
  input  logic [9:0]  line_bytes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        line_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] pixel_word,
  output logic [5:0]  word_index,
  output logic [3:0]  valid_bytes,
  output logic        line_end,
  output logic        run_last
);

  localparam int WORDS = (MAX_LINE_BYTES + 7) / 8;

  logic [sbzd_pkg::LB_W-1:0] line_len;
  logic                      req_valid;
  logic                      req_ready;
  sbzd_pkg::word_t           req;
  sbzd_pkg::word_t           res;

  // Line length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_len <= sbzd_pkg::LB_RESET;
    end else if (line_bytes_we) begin
      line_len <= line_bytes;
    end
  end

  sbzd_sequencer #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .line_bytes (line_len),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .line_start (line_start),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req)
  );

  sbzd_word_unit #(
    .WORDS (WORDS)
  ) u_word (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Result fields.
  assign pixel_word  = res.data;
  assign word_index  = res.idx;
  assign valid_bytes = res.nbytes;
  assign line_end    = res.line_end;
  assign run_last    = res.run_last;

`ifndef SYNTHESIS
  // Only the last word of a line may be short.
  a_short_word_ends_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end |-> valid_bytes == 4'd8)
    else $error("short word before the end of the line");

  // The final word of a line always closes the results of its input byte.
  a_line_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> run_last)
    else $error("line end word without run_last");

  // The sequencer hands over no word while it waits for input.
  a_no_word_while_waiting: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !req_valid)
    else $error("word pushed while waiting for input");

  // Every delivered word holds one to eight bytes.
  a_byte_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> valid_bytes != 4'd0 && valid_bytes <= 4'd8)
    else $error("byte count out of range");
`endif

endmodule
